// File: hw/rtl/ppr_pkg.sv
package ppr_pkg;

	// coordinate and datapath widths
	localparam int CW = 24;
	localparam int DW = CW + 1;
	localparam int HW = (CW + 2 > 26) ? CW + 2 : 26;
	localparam int PW = 2 * HW;
	localparam int AW = 4 * HW + 2;
	localparam int THR_W = 52;
	localparam int TOL_W = 24;
	localparam int CFG_IW = 2;
	localparam int STEP_W = 4;

	// configuration register indexes
	localparam logic [CFG_IW-1:0] REG_THR = 2'd0;
	localparam logic [CFG_IW-1:0] REG_TOL = 2'd1;

	// pass phases
	typedef logic [1:0] phase_t;
	localparam phase_t PH_NONE = 2'd0;
	localparam phase_t PH_KEPT = 2'd1;
	localparam phase_t PH_PEND = 2'd2;

	typedef enum logic [6:0] {
		S_IDLE   = 7'b0000001,
		S_P1     = 7'b0000010,
		S_MUL    = 7'b0000100,
		S_P1_DEC = 7'b0001000,
		S_P2     = 7'b0010000,
		S_P2_DEC = 7'b0100000,
		S_EMIT   = 7'b1000000
	} state_t;

	typedef enum logic [1:0] {M_TURN, M_NEAR, M_FAR} mode_t;

	typedef enum logic [3:0] {
		OP_D0, OP_D1, OP_D2, OP_D3, OP_TOL,
		OP_CLO, OP_CHI, OP_TLO, OP_THI, OP_LLO, OP_LHI
	} opnd_t;

	typedef enum logic [1:0] {SH_0, SH_H, SH_2H} shift_t;

	// one step of the multiply-accumulate program
	typedef struct packed {
		opnd_t  a;
		opnd_t  b;
		shift_t sh;
		logic   sub;
		logic   clr;
		logic   lat_c;
		logic   lat_l;
		logic   lat_t;
		logic   last;
	} ustep_t;

	// microprogram: turn test, point distance, segment distance
	function automatic ustep_t ucode(input mode_t m, input logic [STEP_W-1:0] s);
		ustep_t u;
		u = '{a: OP_D0, b: OP_D0, sh: SH_0, sub: 1'b0, clr: 1'b0,
			lat_c: 1'b0, lat_l: 1'b0, lat_t: 1'b0, last: 1'b0};
		case (m)
			M_TURN: begin
				case (s)
					4'd0: begin u.a = OP_D0; u.b = OP_D1; u.clr = 1'b1; end
					default: begin u.a = OP_D2; u.b = OP_D3; u.sub = 1'b1; u.last = 1'b1; end
				endcase
			end
			M_NEAR: begin
				case (s)
					4'd0: begin u.a = OP_D0; u.b = OP_D0; u.clr = 1'b1; end
					4'd1: begin u.a = OP_D1; u.b = OP_D1; end
					default: begin u.a = OP_TOL; u.b = OP_TOL; u.sub = 1'b1; u.last = 1'b1; end
				endcase
			end
			default: begin
				case (s)
					4'd0: begin u.a = OP_D3; u.b = OP_D0; u.clr = 1'b1; end
					4'd1: begin u.a = OP_D2; u.b = OP_D1; u.sub = 1'b1; end
					4'd2: begin u.lat_c = 1'b1; u.a = OP_D2; u.b = OP_D2; u.clr = 1'b1; end
					4'd3: begin u.a = OP_D3; u.b = OP_D3; end
					4'd4: begin u.lat_l = 1'b1; u.a = OP_TOL; u.b = OP_TOL; u.clr = 1'b1; end
					4'd5: begin u.lat_t = 1'b1; u.a = OP_CLO; u.b = OP_CLO; u.clr = 1'b1; end
					4'd6: begin u.a = OP_CLO; u.b = OP_CHI; u.sh = SH_H; end
					4'd7: begin u.a = OP_CLO; u.b = OP_CHI; u.sh = SH_H; end
					4'd8: begin u.a = OP_CHI; u.b = OP_CHI; u.sh = SH_2H; end
					4'd9: begin u.a = OP_TLO; u.b = OP_LLO; u.sub = 1'b1; end
					4'd10: begin u.a = OP_TLO; u.b = OP_LHI; u.sh = SH_H; u.sub = 1'b1; end
					4'd11: begin u.a = OP_THI; u.b = OP_LLO; u.sh = SH_H; u.sub = 1'b1; end
					default: begin
						u.a = OP_THI; u.b = OP_LHI; u.sh = SH_2H; u.sub = 1'b1; u.last = 1'b1;
					end
				endcase
			end
		endcase
		return u;
	endfunction

endpackage

// File: hw/rtl/polyline_point_reducer_unit.sv
// a vertex is taken only in the idle state, so a new vertex waits until the last one is through;
//   a vertex may need no test, the turn test, a point-distance test or a segment-distance test,
//   and every test runs on the single shared multiply-accumulate unit that walks each test
//   step by step, one product per cycle
// reset: arst_n clears both passes to awaiting ring start and both registers to zero
module polyline_point_reducer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic signed [ppr_pkg::CW-1:0]      point_x,
	input  logic signed [ppr_pkg::CW-1:0]      point_y,
	input  logic                               ring_end,
	output logic                               out_valid,
	input  logic                               out_ready,
	output logic signed [ppr_pkg::CW-1:0]      kept_x,
	output logic signed [ppr_pkg::CW-1:0]      kept_y,
	output logic                               kept_end,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [ppr_pkg::CFG_IW-1:0]         cfg_index,
	input  logic [ppr_pkg::THR_W-1:0]          cfg_data
);

	localparam int CW = ppr_pkg::CW;
	localparam int DW = ppr_pkg::DW;
	localparam int HW = ppr_pkg::HW;
	localparam int PW = ppr_pkg::PW;
	localparam int AW = ppr_pkg::AW;

	ppr_pkg::state_t state_q;
	ppr_pkg::mode_t  mode_q;
	logic [ppr_pkg::STEP_W-1:0] step_q;

	logic [ppr_pkg::THR_W-1:0] thr_q;
	logic [ppr_pkg::TOL_W-1:0] tol_q;

	logic [CW-1:0] in_x_q, in_y_q;
	logic          in_last_q;
	logic [CW-1:0] f_kx_q, f_ky_q, f_px_q, f_py_q;
	ppr_pkg::phase_t f_phase_q;
	logic [CW-1:0] s_kx_q, s_ky_q, s_px_q, s_py_q;
	ppr_pkg::phase_t s_phase_q;
	logic [CW-1:0] cur_x_q, cur_y_q;
	logic          cur_last_q;
	logic          tail_q;

	logic          e0_v_q, e1_v_q, e0_end_q;
	logic [CW-1:0] e0_x_q, e0_y_q, e1_x_q, e1_y_q;

	logic          out_valid_q, kept_end_q;
	logic [CW-1:0] kept_x_q, kept_y_q;

	logic [3:0][DW-1:0] dmag_q;
	logic [3:0]         dneg_q;
	logic [AW-1:0]      acc_q;
	logic [PW-1:0]      cm_q, len_q, tol2_q;

	// difference operands for the test being started
	logic [3:0][CW-1:0] dpa, dpb;
	logic [3:0][DW-1:0] dif, dmag;
	logic [3:0]         dneg;
	logic               seg_zero;

	always_comb begin
		if (state_q == ppr_pkg::S_P1) begin
			dpa[0] = f_py_q;  dpb[0] = f_ky_q;
			dpa[1] = in_x_q;  dpb[1] = f_px_q;
			dpa[2] = in_y_q;  dpb[2] = f_py_q;
			dpa[3] = f_px_q;  dpb[3] = f_kx_q;
		end else begin
			dpa[0] = s_px_q;  dpb[0] = s_kx_q;
			dpa[1] = s_py_q;  dpb[1] = s_ky_q;
			dpa[2] = cur_x_q; dpb[2] = s_kx_q;
			dpa[3] = cur_y_q; dpb[3] = s_ky_q;
		end
		for (int i = 0; i < 4; i++) begin
			dif[i]  = {dpa[i][CW-1], dpa[i]} - {dpb[i][CW-1], dpb[i]};
			dneg[i] = dif[i][DW-1];
			dmag[i] = dneg[i] ? (~dif[i] + DW'(1)) : dif[i];
		end
		seg_zero = (dif[2] == '0) && (dif[3] == '0);
	end

	// shared multiply-accumulate unit
	ppr_pkg::ustep_t u;
	logic [HW-1:0] opa, opb;
	logic          sga, sgb, tneg;
	logic [PW-1:0] prod;
	logic [AW-1:0] term, acc_nx, acc_abs;
	logic          keep_turn, keep_dist;

	function automatic logic [HW:0] pick(input ppr_pkg::opnd_t s,
		input logic [3:0][DW-1:0] m, input logic [3:0] n, input logic [ppr_pkg::TOL_W-1:0] t,
		input logic [PW-1:0] c, input logic [PW-1:0] l, input logic [PW-1:0] t2);
		logic [HW:0] r;
		case (s)
			ppr_pkg::OP_D0:  r = {n[0], HW'(m[0])};
			ppr_pkg::OP_D1:  r = {n[1], HW'(m[1])};
			ppr_pkg::OP_D2:  r = {n[2], HW'(m[2])};
			ppr_pkg::OP_D3:  r = {n[3], HW'(m[3])};
			ppr_pkg::OP_TOL: r = {1'b0, HW'(t)};
			ppr_pkg::OP_CLO: r = {1'b0, c[HW-1:0]};
			ppr_pkg::OP_CHI: r = {1'b0, c[PW-1:HW]};
			ppr_pkg::OP_TLO: r = {1'b0, t2[HW-1:0]};
			ppr_pkg::OP_THI: r = {1'b0, t2[PW-1:HW]};
			ppr_pkg::OP_LLO: r = {1'b0, l[HW-1:0]};
			ppr_pkg::OP_LHI: r = {1'b0, l[PW-1:HW]};
			default:         r = '0;
		endcase
		return r;
	endfunction

	always_comb begin
		u = ppr_pkg::ucode(mode_q, step_q);
		{sga, opa} = pick(u.a, dmag_q, dneg_q, tol_q, cm_q, len_q, tol2_q);
		{sgb, opb} = pick(u.b, dmag_q, dneg_q, tol_q, cm_q, len_q, tol2_q);
		prod = opa * opb;
		case (u.sh)
			ppr_pkg::SH_H:  term = AW'(prod) << HW;
			ppr_pkg::SH_2H: term = AW'(prod) << (2 * HW);
			default:        term = AW'(prod);
		endcase
		tneg = sga ^ sgb ^ u.sub;
		acc_nx = (u.clr ? '0 : acc_q) + (term ^ {AW{tneg}}) + AW'(tneg);
		acc_abs = acc_q[AW-1] ? (~acc_q + AW'(1)) : acc_q;
		keep_turn = acc_abs >= AW'(thr_q);
		keep_dist = !acc_q[AW-1];
	end

	logic out_free;
	logic load_out;
	assign out_free  = !out_valid_q || out_ready;
	assign load_out  = (state_q == ppr_pkg::S_EMIT) && (e0_v_q || e1_v_q) && out_free;
	assign in_ready  = (state_q == ppr_pkg::S_IDLE);
	assign cfg_ready = 1'b1;
	assign out_valid = out_valid_q;
	assign kept_x    = kept_x_q;
	assign kept_y    = kept_y_q;
	assign kept_end  = kept_end_q;

	// sequencer and datapath registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ppr_pkg::S_IDLE;
			mode_q <= ppr_pkg::M_TURN;
			step_q <= '0;
			thr_q <= '0;
			tol_q <= '0;
			in_x_q <= '0; in_y_q <= '0; in_last_q <= 1'b0;
			f_kx_q <= '0; f_ky_q <= '0; f_px_q <= '0; f_py_q <= '0;
			f_phase_q <= ppr_pkg::PH_NONE;
			s_kx_q <= '0; s_ky_q <= '0; s_px_q <= '0; s_py_q <= '0;
			s_phase_q <= ppr_pkg::PH_NONE;
			cur_x_q <= '0; cur_y_q <= '0; cur_last_q <= 1'b0;
			tail_q <= 1'b0;
			e0_v_q <= 1'b0; e1_v_q <= 1'b0; e0_end_q <= 1'b0;
			e0_x_q <= '0; e0_y_q <= '0; e1_x_q <= '0; e1_y_q <= '0;
			out_valid_q <= 1'b0; kept_end_q <= 1'b0;
			kept_x_q <= '0; kept_y_q <= '0;
			dmag_q <= '0; dneg_q <= '0;
			acc_q <= '0; cm_q <= '0; len_q <= '0; tol2_q <= '0;
		end else begin
			// configuration writes
			if (cfg_valid) begin
				unique case (cfg_index)
					ppr_pkg::REG_THR: thr_q <= cfg_data;
					ppr_pkg::REG_TOL: tol_q <= cfg_data[ppr_pkg::TOL_W-1:0];
					default: ;
				endcase
			end

			// output register loads or drains
			if (load_out)
				out_valid_q <= 1'b1;
			else if (out_valid_q && out_ready)
				out_valid_q <= 1'b0;

			unique case (state_q)
				ppr_pkg::S_IDLE: begin
					if (in_valid) begin
						in_x_q <= point_x;
						in_y_q <= point_y;
						in_last_q <= ring_end;
						state_q <= ppr_pkg::S_P1;
					end
				end
				ppr_pkg::S_P1: begin
					dmag_q <= dmag;
					dneg_q <= dneg;
					step_q <= '0;
					mode_q <= ppr_pkg::M_TURN;
					state_q <= (f_phase_q == ppr_pkg::PH_PEND) ? ppr_pkg::S_MUL : ppr_pkg::S_P1_DEC;
				end
				ppr_pkg::S_MUL: begin
					acc_q <= acc_nx;
					if (u.lat_c) cm_q <= acc_abs[PW-1:0];
					if (u.lat_l) len_q <= acc_q[PW-1:0];
					if (u.lat_t) tol2_q <= acc_q[PW-1:0];
					step_q <= step_q + 4'd1;
					if (u.last)
						state_q <= (mode_q == ppr_pkg::M_TURN) ? ppr_pkg::S_P1_DEC : ppr_pkg::S_P2_DEC;
				end
				ppr_pkg::S_P1_DEC: begin
					case (f_phase_q)
						ppr_pkg::PH_KEPT: begin
							if (in_last_q) begin
								cur_x_q <= in_x_q; cur_y_q <= in_y_q; cur_last_q <= 1'b1;
								tail_q <= 1'b0;
								f_phase_q <= ppr_pkg::PH_NONE;
								state_q <= ppr_pkg::S_P2;
							end else begin
								f_px_q <= in_x_q; f_py_q <= in_y_q;
								f_phase_q <= ppr_pkg::PH_PEND;
								state_q <= ppr_pkg::S_IDLE;
							end
						end
						ppr_pkg::PH_PEND: begin
							if (keep_turn) begin
								cur_x_q <= f_px_q; cur_y_q <= f_py_q; cur_last_q <= 1'b0;
								f_kx_q <= f_px_q; f_ky_q <= f_py_q;
								tail_q <= in_last_q;
								state_q <= ppr_pkg::S_P2;
							end else if (in_last_q) begin
								cur_x_q <= in_x_q; cur_y_q <= in_y_q; cur_last_q <= 1'b1;
								tail_q <= 1'b0;
								state_q <= ppr_pkg::S_P2;
							end else begin
								state_q <= ppr_pkg::S_IDLE;
							end
							if (in_last_q)
								f_phase_q <= ppr_pkg::PH_NONE;
							else begin
								f_px_q <= in_x_q; f_py_q <= in_y_q;
							end
						end
						default: begin
							cur_x_q <= in_x_q; cur_y_q <= in_y_q; cur_last_q <= 1'b0;
							f_kx_q <= in_x_q; f_ky_q <= in_y_q;
							tail_q <= in_last_q;
							f_phase_q <= in_last_q ? ppr_pkg::PH_NONE : ppr_pkg::PH_KEPT;
							state_q <= ppr_pkg::S_P2;
						end
					endcase
				end
				ppr_pkg::S_P2: begin
					dmag_q <= dmag;
					dneg_q <= dneg;
					step_q <= '0;
					mode_q <= seg_zero ? ppr_pkg::M_NEAR : ppr_pkg::M_FAR;
					state_q <= (s_phase_q == ppr_pkg::PH_PEND) ? ppr_pkg::S_MUL : ppr_pkg::S_P2_DEC;
				end
				ppr_pkg::S_P2_DEC: begin
					case (s_phase_q)
						ppr_pkg::PH_KEPT: begin
							e0_v_q <= cur_last_q;
							e1_v_q <= 1'b0;
							e0_x_q <= cur_x_q; e0_y_q <= cur_y_q;
							e0_end_q <= 1'b1;
							if (cur_last_q) begin
								s_phase_q <= ppr_pkg::PH_NONE;
							end else begin
								s_px_q <= cur_x_q; s_py_q <= cur_y_q;
								s_phase_q <= ppr_pkg::PH_PEND;
							end
						end
						ppr_pkg::PH_PEND: begin
							e0_v_q <= keep_dist;
							e0_x_q <= s_px_q; e0_y_q <= s_py_q;
							e0_end_q <= 1'b0;
							if (keep_dist) begin
								s_kx_q <= s_px_q; s_ky_q <= s_py_q;
							end
							e1_v_q <= cur_last_q;
							e1_x_q <= cur_x_q; e1_y_q <= cur_y_q;
							if (cur_last_q) begin
								s_phase_q <= ppr_pkg::PH_NONE;
							end else begin
								s_px_q <= cur_x_q; s_py_q <= cur_y_q;
							end
						end
						default: begin
							e0_v_q <= 1'b1;
							e1_v_q <= 1'b0;
							e0_x_q <= cur_x_q; e0_y_q <= cur_y_q;
							e0_end_q <= cur_last_q;
							s_kx_q <= cur_x_q; s_ky_q <= cur_y_q;
							s_phase_q <= cur_last_q ? ppr_pkg::PH_NONE : ppr_pkg::PH_KEPT;
						end
					endcase
					state_q <= ppr_pkg::S_EMIT;
				end
				ppr_pkg::S_EMIT: begin
					if (e0_v_q) begin
						if (out_free) begin
							kept_x_q <= e0_x_q; kept_y_q <= e0_y_q; kept_end_q <= e0_end_q;
							e0_v_q <= 1'b0;
						end
					end else if (e1_v_q) begin
						if (out_free) begin
							kept_x_q <= e1_x_q; kept_y_q <= e1_y_q; kept_end_q <= 1'b1;
							e1_v_q <= 1'b0;
						end
					end else if (tail_q) begin
						cur_x_q <= in_x_q; cur_y_q <= in_y_q; cur_last_q <= 1'b1;
						tail_q <= 1'b0;
						state_q <= ppr_pkg::S_P2;
					end else begin
						state_q <= ppr_pkg::S_IDLE;
					end
				end
				default: state_q <= ppr_pkg::S_IDLE;
			endcase
		end
	end

	// a transaction always starts pass one next
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> state_q == ppr_pkg::S_P1)
		else $error("accepted vertex did not start pass one");

	// the multiply program never runs past its longest sequence
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppr_pkg::S_MUL |-> step_q <= 4'd12)
		else $error("multiply step counter overran");

	// unused phase code is never reached
	a_phase_legal: assert property (@(posedge clk) disable iff (!arst_n)
		f_phase_q != 2'd3 && s_phase_q != 2'd3)
		else $error("pass phase reached unused code");

	// a pass-two decision is always followed by emission
	a_dec_emit: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ppr_pkg::S_P2_DEC |=> state_q == ppr_pkg::S_EMIT)
		else $error("pass two decision not followed by emission");

endmodule

// File: sim/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CW = ppr_pkg::CW;
	localparam int CFG_IW = ppr_pkg::CFG_IW;
	localparam int THR_W = ppr_pkg::THR_W;
	localparam int TOL_W = ppr_pkg::TOL_W;

	// indexes past the register list
	localparam logic [CFG_IW-1:0] REG_SPARE_A = 2'd2;
	localparam logic [CFG_IW-1:0] REG_SPARE_B = 2'd3;

	localparam int N_RANDOM = 430;
	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES = 60;

	typedef struct {
		logic signed [CW-1:0] x;
		logic signed [CW-1:0] y;
		logic                 e;
	} vertex_t;

	// directed stimulus row: vertex plus optional typed expectation
	typedef struct {
		vertex_t v;
		int      n_typed;
		vertex_t typed [3];
	} stim_row_t;

	logic clk;
	logic arst_n;
	logic in_valid, in_ready;
	logic signed [CW-1:0] point_x, point_y;
	logic ring_end;
	logic out_valid, out_ready;
	logic signed [CW-1:0] kept_x, kept_y;
	logic kept_end;
	logic cfg_valid, cfg_ready;
	logic [CFG_IW-1:0] cfg_index;
	logic [THR_W-1:0] cfg_data;

	polyline_point_reducer_unit u_dut (.*);

	// predictor state
	logic [THR_W-1:0] thr_q;
	logic [TOL_W-1:0] tol_q;
	logic signed [CW-1:0] p1_kx, p1_ky, p1_px, p1_py;
	logic signed [CW-1:0] p2_kx, p2_ky, p2_px, p2_py;
	ppr_pkg::phase_t p1_ph, p2_ph;

	vertex_t kept_queue [$];
	int errors = 0;
	int n_checked = 0;
	int idle_cycles = 0;
	bit rx_calm = 0;
	bit tx_calm = 0;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	task automatic report_mismatch(input string what, input vertex_t got, input vertex_t want);
		errors++;
		$display("mismatch %s: got (%0d,%0d,%0b) want (%0d,%0d,%0b) at %0t", what,
			got.x, got.y, got.e, want.x, want.y, want.e, $realtime);
	endtask

	// exact turn test, pass one
	function automatic bit turn_kept(input logic signed [CW-1:0] kx, ky, cx, cy, nx, ny);
		logic signed [63:0] a, b, g, h;
		logic signed [127:0] c;
		a = 64'(cy) - 64'(ky);
		b = 64'(nx) - 64'(cx);
		g = 64'(ny) - 64'(cy);
		h = 64'(cx) - 64'(kx);
		c = 128'(a) * 128'(b) - 128'(g) * 128'(h);
		if (c < 0) c = -c;
		return c >= $signed({76'd0, thr_q});
	endfunction

	// exact distance test, pass two
	function automatic bit far_kept(input logic signed [CW-1:0] kx, ky, cx, cy, nx, ny);
		logic signed [63:0] dx, dy, ex, ey;
		logic signed [255:0] c, len2, tol2;
		dx = 64'(nx) - 64'(kx);
		dy = 64'(ny) - 64'(ky);
		ex = 64'(cx) - 64'(kx);
		ey = 64'(cy) - 64'(ky);
		tol2 = $signed({232'd0, tol_q}) * $signed({232'd0, tol_q});
		if (dx == 0 && dy == 0)
			return 256'(ex) * 256'(ex) + 256'(ey) * 256'(ey) >= tol2;
		c = 256'(dy) * 256'(ex) - 256'(dx) * 256'(ey);
		len2 = 256'(dx) * 256'(dx) + 256'(dy) * 256'(dy);
		return c * c >= tol2 * len2;
	endfunction

	function automatic void push_kept(input logic signed [CW-1:0] x, y, input logic e);
		vertex_t k;
		k.x = x; k.y = y; k.e = e;
		kept_queue.insert(kept_queue.size(), k);
	endfunction

	function automatic void distance_pass(input logic signed [CW-1:0] x, y, input bit last);
		if (p2_ph == ppr_pkg::PH_KEPT) begin
			if (last) begin
				push_kept(x, y, 1'b1); p2_ph = ppr_pkg::PH_NONE;
			end else begin
				p2_px = x; p2_py = y; p2_ph = ppr_pkg::PH_PEND;
			end
		end else if (p2_ph == ppr_pkg::PH_PEND) begin
			if (far_kept(p2_kx, p2_ky, p2_px, p2_py, x, y)) begin
				push_kept(p2_px, p2_py, 1'b0);
				p2_kx = p2_px; p2_ky = p2_py;
			end
			if (last) begin
				push_kept(x, y, 1'b1); p2_ph = ppr_pkg::PH_NONE;
			end else begin
				p2_px = x; p2_py = y;
			end
		end else begin
			push_kept(x, y, last);
			p2_kx = x; p2_ky = y;
			p2_ph = last ? ppr_pkg::PH_NONE : ppr_pkg::PH_KEPT;
		end
	endfunction

	function automatic void predict_vertex(input vertex_t v);
		if (p1_ph == ppr_pkg::PH_KEPT) begin
			if (v.e) begin
				distance_pass(v.x, v.y, 1); p1_ph = ppr_pkg::PH_NONE;
			end else begin
				p1_px = v.x; p1_py = v.y; p1_ph = ppr_pkg::PH_PEND;
			end
		end else if (p1_ph == ppr_pkg::PH_PEND) begin
			if (turn_kept(p1_kx, p1_ky, p1_px, p1_py, v.x, v.y)) begin
				distance_pass(p1_px, p1_py, 0);
				p1_kx = p1_px; p1_ky = p1_py;
			end
			if (v.e) begin
				distance_pass(v.x, v.y, 1); p1_ph = ppr_pkg::PH_NONE;
			end else begin
				p1_px = v.x; p1_py = v.y;
			end
		end else begin
			distance_pass(v.x, v.y, 0);
			p1_kx = v.x; p1_ky = v.y;
			if (v.e) begin
				distance_pass(v.x, v.y, 1); p1_ph = ppr_pkg::PH_NONE;
			end else
				p1_ph = ppr_pkg::PH_KEPT;
		end
	endfunction

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [THR_W-1:0] val);
		in_valid <= 1'b0;
		cfg_valid <= 1'b1; cfg_index <= idx; cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == ppr_pkg::REG_THR) thr_q = val;
		else if (idx == ppr_pkg::REG_TOL) tol_q = val[TOL_W-1:0];
		@(negedge clk);
	endtask

	task automatic send_vertex(input vertex_t v);
		cfg_valid <= 1'b0;
		while (!tx_calm && $urandom_range(99) < 20) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1; point_x <= v.x; point_y <= v.y; ring_end <= v.e;
		do @(posedge clk); while (!in_ready);
		predict_vertex(v);
		@(negedge clk);
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		cfg_valid <= 1'b0;
		while (kept_queue.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	function automatic vertex_t vx(input int x, y, input bit e);
		vertex_t v;
		v.x = CW'(x); v.y = CW'(y); v.e = e;
		return v;
	endfunction

	function automatic int rnd_coord(input int span);
		if ($urandom_range(9) == 0) return $signed($urandom_range(32'hFFFFFF)) <<< 8 >>> 8;
		return $signed($urandom_range(2 * span)) - span;
	endfunction

	// result checker
	always @(posedge clk) begin
		vertex_t got, want;
		if (arst_n && out_valid && out_ready) begin
			got.x = kept_x; got.y = kept_y; got.e = kept_end;
			if (kept_queue.size() == 0) begin
				want = got;
				report_mismatch("unexpected", got, want);
			end else begin
				want = kept_queue.pop_front();
				n_checked++;
				if (got.x !== want.x) report_mismatch("kept_x", got, want);
				if (got.y !== want.y) report_mismatch("kept_y", got, want);
				if (got.e !== want.e) report_mismatch("kept_end", got, want);
			end
		end
	end

	// receiver stalls
	always @(negedge clk)
		out_ready <= rx_calm ? 1'b1 : ($urandom_range(99) >= 20);

	// watchdog on accepted transactions
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("watchdog expired at %0t", $realtime);
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin
		stim_row_t rows [$];
		stim_row_t r;
		int len, span, ring;
		vertex_t v;
		arst_n = 1'b0;
		in_valid = 1'b0; point_x = '0; point_y = '0; ring_end = 1'b0;
		out_ready = 1'b0;
		cfg_valid = 1'b0; cfg_index = ppr_pkg::REG_THR; cfg_data = '0;
		thr_q = '0; tol_q = '0;
		p1_ph = ppr_pkg::PH_NONE; p2_ph = ppr_pkg::PH_NONE;
		p1_kx = '0; p1_ky = '0; p1_px = '0; p1_py = '0;
		p2_kx = '0; p2_ky = '0; p2_px = '0; p2_py = '0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed table, zero registers: nothing dropped
		r.n_typed = 2; r.v = vx(8388607, -8388608, 1);
		r.typed[0] = vx(8388607, -8388608, 0); r.typed[1] = vx(8388607, -8388608, 1);
		rows.insert(rows.size(), r);
		r.n_typed = 2; r.v = vx(-8388608, 8388607, 1);
		r.typed[0] = vx(-8388608, 8388607, 0); r.typed[1] = vx(-8388608, 8388607, 1);
		rows.insert(rows.size(), r);
		r.n_typed = 1; r.v = vx(0, 0, 0); r.typed[0] = vx(0, 0, 0); rows.insert(rows.size(), r);
		r.n_typed = 1; r.v = vx(5, 5, 1); r.typed[0] = vx(5, 5, 1); rows.insert(rows.size(), r);
		r.n_typed = -1;
		r.v = vx(-8388608, -8388608, 0); rows.insert(rows.size(), r);
		r.v = vx(8388607, 8388607, 0); rows.insert(rows.size(), r);
		r.v = vx(-8388608, 8388607, 0); rows.insert(rows.size(), r);
		r.v = vx(8388607, -8388608, 0); rows.insert(rows.size(), r);
		r.v = vx(-8388608, -8388608, 1); rows.insert(rows.size(), r);
		foreach (rows[i]) begin
			vertex_t got;
			if (rows[i].n_typed > 0)
				wait_drained();
			send_vertex(rows[i].v);
			for (int k = 0; k < rows[i].n_typed; k++) begin
				got = kept_queue[k];
				if (got.x !== rows[i].typed[k].x || got.y !== rows[i].typed[k].y ||
					got.e !== rows[i].typed[k].e)
					report_mismatch($sformatf("table row %0d", i), got, rows[i].typed[k]);
			end
		end
		wait_drained();

		// nearly collinear runs and zero-length segments under small and max settings
		for (int s = 0; s < 3; s++) begin
			write_reg(ppr_pkg::REG_THR, s == 0 ? 52'd1 : (s == 1 ? 52'd20 : {THR_W{1'b1}}));
			write_reg(ppr_pkg::REG_TOL, s == 0 ? 52'd1 : (s == 1 ? 52'd3 : 52'hFFFFFF));
			send_vertex(vx(0, 0, 0));
			send_vertex(vx(10, 0, 0));
			send_vertex(vx(20, 1, 0));
			send_vertex(vx(0, 0, 0));
			send_vertex(vx(0, 4, 0));
			send_vertex(vx(0, 0, 1));
			wait_drained();
		end
		write_reg(REG_SPARE_B, 52'd7);
		write_reg(REG_SPARE_A, 52'd7);

		// random rings across several settings; last stretch runs without stalls
		ring = 0;
		for (int sent = 0; sent < N_RANDOM; ) begin
			if (ring % 12 == 0) begin
				wait_drained();
				case ($urandom_range(3))
					0: begin
						write_reg(ppr_pkg::REG_THR, '0);
						write_reg(ppr_pkg::REG_TOL, '0);
					end
					1: begin
						write_reg(ppr_pkg::REG_THR, THR_W'({$urandom, $urandom}));
						write_reg(ppr_pkg::REG_TOL, THR_W'($urandom));
					end
					default: begin
						write_reg(ppr_pkg::REG_THR, THR_W'($urandom_range(200)));
						write_reg(ppr_pkg::REG_TOL, THR_W'($urandom_range(8)));
					end
				endcase
			end
			rx_calm = (sent >= N_RANDOM - 80);
			tx_calm = rx_calm;
			len = $urandom_range(1, 9);
			span = $urandom_range(1) ? 20 : 8000;
			for (int k = 0; k < len; k++) begin
				v = vx(rnd_coord(span), rnd_coord(span), k == len - 1);
				send_vertex(v);
			end
			sent += len;
			ring++;
		end
		wait_drained();

		$display("covered %0d rings, %0d kept vertices checked", ring, n_checked);
		if (errors == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/ppr_pkg.sv
hw/rtl/polyline_point_reducer_unit.sv
sim/tb.sv
